FILE: rtl/mlp_backprop_train_step_assert.svh
// assertion macros used by the top-level rtl file
`ifndef MLP_BACKPROP_TRAIN_STEP_ASSERT_SVH
`define MLP_BACKPROP_TRAIN_STEP_ASSERT_SVH

// condition implies consequence in the same cycle
`define MBP_ASSERT_SAME(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define MBP_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mbp_pkg;

    localparam int INPUT_COUNT      = 25;
    localparam int HIDDEN_COUNT     = 10;
    localparam int TANH_TABLE_DEPTH = 256;

    localparam int NCOLS    = INPUT_COUNT + 1;
    localparam int NROWS    = HIDDEN_COUNT + 1;
    localparam int HW_DEPTH = NROWS * NCOLS;
    localparam int COL_W    = (NCOLS > 1) ? $clog2(NCOLS) : 1;
    localparam int ROW_W    = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int TAB_AW   = $clog2(TANH_TABLE_DEPTH);

    // reciprocal of the row length for splitting a flat weight index
    localparam int RECIP_SH = 24;
    localparam int RECIP    = ((1 << RECIP_SH) + NCOLS - 1) / NCOLS;

    localparam int W_W    = 16;
    localparam int H_W    = 14;
    localparam int LR_W   = 13;
    localparam int THR_W  = 13;
    localparam int ACC_W  = W_W + COL_W;
    localparam int MAC_W  = W_W + H_W + ROW_W;
    localparam int TH_W   = 32;
    localparam int OD_W   = 15;
    localparam int LROD_W = LR_W + 1 + OD_W;
    localparam int HHC_W  = 26;
    localparam int ODW_W  = OD_W + W_W;
    localparam int HDP_W  = HHC_W + ODW_W;
    localparam int HD_W   = 18;
    localparam int WUP_W  = LROD_W + H_W;
    localparam int LRHD_W = LR_W + 1 + HD_W;
    localparam int DW_W   = 20;

    localparam int ONE_Q12 = 4096;
    localparam int ONE_Q24 = 1 << 24;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    localparam logic [1:0] MODE_INFER = 2'd0;
    localparam logic [1:0] MODE_TRAIN = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    localparam logic [1:0] CFG_THR  = 2'd0;
    localparam logic [1:0] CFG_LR   = 2'd1;
    localparam logic [1:0] CFG_BIAS = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_HSUM, S_HWAIT, S_HTANH, S_OSUM, S_OTANH, S_SNAP,
        S_OD1, S_OD2, S_OD3, S_OD4, S_OD5, S_OD6, S_OD7, S_OD8,
        S_UPD, S_UPWAIT, S_DONE
    } t_state;

    typedef logic signed [H_W-1:0] t_h;
    typedef logic signed [W_W-1:0] t_w;
    typedef t_h [NROWS-1:0] t_h_vec;
    typedef t_w [NROWS-1:0] t_w_vec;

    typedef struct packed {
        logic             acc_clr;
        logic             acc_en;
        logic             h_load;
        logic             hhc_load;
        logic             odw_load;
        logic             prod_load;
        logic             hd_load;
        logic             lrhd_load;
        logic             dw_load;
        logic             upd_we;
        logic             x_pos;
        logic [COL_W-1:0] raddr;
        logic [COL_W-1:0] waddr;
    } t_lane_ctl;

    typedef logic [12:0] t_tab [TANH_TABLE_DEPTH];

    // shift and subtract long division, used only while the table is built
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4k/depth) in q12 via an integer series for exp(-2x)
    function automatic t_tab build_tab();
        t_tab              tab;
        longint unsigned   f;
        longint unsigned   term;
        longint unsigned   sum;
        longint unsigned   e;
        longint unsigned   one;
        for (int k = 0; k < TANH_TABLE_DEPTH; k++) begin
            one  = 64'd1 << 30;
            f    = (longint'(k) << 30) / TANH_TABLE_DEPTH;
            term = one;
            sum  = one;
            for (int n = 1; n <= 24; n++) begin
                term = udiv64((term * f) >> 30, longint'(n));
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            e = sum;
            for (int n = 0; n < 3; n++) begin
                e = (e * e) >> 30;
            end
            if (e > one) begin
                e = one;
            end
            tab[k] = 13'(udiv64(((one - e) << 12) + ((one + e) >> 1), one + e));
        end
        return tab;
    endfunction

    localparam t_tab TANH_TAB = build_tab();

    // rescale with rounding to nearest, ties away from zero
    function automatic logic signed [63:0] round_sh(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_w sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) begin
            return 16'sh7fff;
        end else if (v < -32'sd32768) begin
            return 16'sh8000;
        end
        return t_w'(v);
    endfunction

    function automatic t_h tanh_q12(input logic signed [TH_W-1:0] s);
        logic [TH_W-1:0]   m;
        logic [31:0]       prod;
        logic [TAB_AW-1:0] idx;
        t_h                r;
        m = s[TH_W-1] ? TH_W'(-s) : TH_W'(s);
        if (m >= TH_W'(16384)) begin
            r = t_h'(ONE_Q12);
        end else begin
            prod = 32'(m[13:0]) * 32'(TANH_TABLE_DEPTH);
            idx  = TAB_AW'(prod >> 14);
            r    = t_h'({1'b0, TANH_TAB[idx]});
        end
        return s[TH_W-1] ? -r : r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/mbp_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module mbp_lane import mbp_pkg::*; (
    input  wire logic                     i_clk,
    input  wire t_lane_ctl                i_ctl,
    input  wire logic                     i_active,
    input  wire logic                     i_is_bias,
    input  wire logic                     i_ld_hid,
    input  wire logic                     i_ld_out,
    input  wire logic [COL_W-1:0]         i_ld_col,
    input  wire logic signed [W_W-1:0]    i_ld_val,
    input  wire logic signed [OD_W-1:0]   i_od,
    input  wire logic signed [LROD_W-1:0] i_lr_od,
    input  wire logic [LR_W-1:0]          i_lr,
    output t_h                            o_h,
    output t_w                            o_wout
);
    logic signed [ACC_W-1:0]  r_acc;
    t_h                       r_h;
    t_w                       r_wout;
    logic signed [HHC_W-1:0]  r_hhc;
    logic signed [ODW_W-1:0]  r_odw;
    logic signed [HDP_W-1:0]  r_hdp;
    logic signed [WUP_W-1:0]  r_wup;
    logic signed [HD_W-1:0]   r_hd;
    logic signed [LRHD_W-1:0] r_lrhd;
    logic signed [DW_W-1:0]   r_dw;

    logic [W_W-1:0]           rdata;
    t_w                       w_rd;
    t_w                       w_new;
    logic                     we;
    logic [COL_W-1:0]         waddr;
    t_w                       wdata;
    logic signed [2*H_W-1:0]  hsq;
    logic signed [LR_W:0]     lr_s;
    logic signed [31:0]       wsum;
    logic signed [31:0]       osum;

    assign w_rd = t_w'(rdata);
    assign lr_s = signed'({1'b0, i_lr});

    always_comb begin
        hsq   = r_h * r_h;
        wsum  = i_ctl.x_pos ? (32'(w_rd) + 32'(r_dw)) : (32'(w_rd) - 32'(r_dw));
        w_new = sat16(wsum);
        osum  = 32'(r_wout) + 32'(round_sh(64'(r_wup), 24));
        we    = i_ld_hid | (i_ctl.upd_we & i_active);
        waddr = i_ld_hid ? i_ld_col : i_ctl.waddr;
        wdata = i_ld_hid ? i_ld_val : w_new;
    end

    mbp_ram #(
        .WIDTH (W_W),
        .DEPTH (NCOLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_ctl.raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= i_ctl.x_pos ? (r_acc + ACC_W'(w_rd)) : (r_acc - ACC_W'(w_rd));
        end
        if (i_ctl.h_load) begin
            r_h <= i_is_bias ? t_h'(ONE_Q12) : tanh_q12(TH_W'(r_acc));
        end
        if (i_ctl.hhc_load) begin
            r_hhc <= HHC_W'(ONE_Q24) - HHC_W'(hsq);
        end
        if (i_ctl.odw_load) begin
            r_odw <= i_od * r_wout;
        end
        if (i_ctl.prod_load) begin
            r_hdp <= r_hhc * r_odw;
            r_wup <= i_lr_od * r_h;
        end
        if (i_ctl.hd_load) begin
            r_hd <= i_is_bias ? '0 : HD_W'(round_sh(64'(r_hdp), 36));
        end
        if (i_ctl.lrhd_load) begin
            r_lrhd <= lr_s * r_hd;
        end
        if (i_ctl.dw_load) begin
            r_dw <= DW_W'(round_sh(64'(r_lrhd), 12));
        end
        // old output weight already captured in r_odw for the hidden delta
        if (i_ld_out) begin
            r_wout <= i_ld_val;
        end else if (i_ctl.hd_load && i_active) begin
            r_wout <= sat16(osum);
        end
    end

    assign o_h    = r_h;
    assign o_wout = r_wout;
endmodule
`default_nettype wire

FILE: rtl/mbp_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module mbp_merge import mbp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_clr,
    input  wire logic             i_en,
    input  wire logic             i_fin,
    input  wire logic [ROW_W-1:0] i_row,
    input  wire t_h_vec           i_h,
    input  wire t_w_vec           i_w,
    output t_h                    o_y
);
    logic signed [MAC_W-1:0]   r_mac;
    t_h                        r_y;
    logic signed [W_W+H_W-1:0] prod;

    assign prod = i_w[i_row] * i_h[i_row];

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_mac <= '0;
        end else if (i_en) begin
            r_mac <= r_mac + MAC_W'(prod);
        end
        if (i_fin) begin
            r_y <= tanh_q12(TH_W'(round_sh(64'(r_mac), 12)));
        end
    end

    assign o_y = r_y;
endmodule
`default_nettype wire

FILE: rtl/mlp_backprop_train_step.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: a weight load or unused mode goes straight to the result state after the input beat;
//   inference sweeps the columns, then the rows; training on a mismatch adds the delta steps and a column update sweep
// throughput: one pattern at a time; the column sweep over the per-lane weight rams and the
//   single output mac set the rate
// reset: i_rst_n synchronous, active low; clears control and restores register defaults,
//   weights stay unknown until loaded
module mlp_backprop_train_step import mbp_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_idx,
    input  wire logic [THR_W-1:0]       i_cfg_data,
    // input beats
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // mode[1:0], pixels[26:2], target[27], weight_index[36:28], weight_value[52:37]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result beats
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // net_output[13:0], decided[14], mismatch[15], weights_updated[16]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);
`include "mlp_backprop_train_step_assert.svh"

    // configuration registers
    logic [THR_W-1:0] r_thr;
    logic [LR_W-1:0]  r_lr;
    logic             r_bias;

    // sequencer
    t_state           r_state, n_state;
    logic [COL_W-1:0] r_cnt;
    logic [ROW_W-1:0] r_row;
    logic             r_rd_v;
    logic             r_rd_upd;
    logic [COL_W-1:0] r_col_d;
    logic             r_x_d;

    // latched beat
    logic [1:0]             r_mode;
    logic [INPUT_COUNT-1:0] r_pix;
    logic                   r_tgt;

    // output side arithmetic
    t_h                         r_o;
    logic                       r_dec;
    logic                       r_mism;
    logic                       r_upd;
    logic signed [HHC_W-1:0]    r_ooc;
    logic signed [HHC_W+OD_W-1:0] r_odp;
    logic signed [OD_W-1:0]     r_od;
    logic signed [LROD_W-1:0]   r_lr_od;

    // result register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out;

    // input field views
    logic [1:0]             in_mode;
    logic [INPUT_COUNT-1:0] in_pix;
    logic                   in_tgt;
    logic [8:0]             in_widx;
    t_w                     in_wval;

    logic                   accept;
    logic                   out_free;
    logic [COL_W-1:0]       ncol_last;
    logic [ROW_W-1:0]       nrow_last;
    logic                   x_cur;
    t_lane_ctl              ctl;
    t_h_vec                 h_vec;
    t_w_vec                 w_vec;
    t_h                     y;

    // weight index split into row and column
    logic [8+RECIP_SH+1:0]  row_prod;
    logic [ROW_W-1:0]       ld_row;
    logic [COL_W-1:0]       ld_col;
    logic [15:0]            ld_rowoff;
    logic                   ld_is_hid;
    logic                   ld_is_out;
    logic [8:0]             ld_out_idx;

    // snap and training terms
    logic signed [H_W:0]          thr_s;
    logic signed [H_W:0]          y_ext;
    t_h                           o_nxt;
    logic                         dec_nxt;
    t_h                           t_val;
    logic signed [H_W:0]          t_m_o;
    logic signed [2*H_W-1:0]      osq;
    logic signed [LR_W:0]         lr_s;

    assign in_mode = s_axis_tdata[1:0];
    assign in_pix  = s_axis_tdata[26:2];
    assign in_tgt  = s_axis_tdata[27];
    assign in_widx = s_axis_tdata[36:28];
    assign in_wval = t_w'(s_axis_tdata[52:37]);

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign ncol_last = r_bias ? COL_W'(NCOLS - 1) : COL_W'(INPUT_COUNT - 1);
    assign nrow_last = r_bias ? ROW_W'(NROWS - 1) : ROW_W'(HIDDEN_COUNT - 1);

    // input value of the current column: bias column first when the bias is on
    always_comb begin
        if (r_bias) begin
            x_cur = (r_cnt == '0) ? 1'b1 : r_pix[COL_W'(r_cnt - 1'b1)];
        end else begin
            x_cur = (32'(r_cnt) < INPUT_COUNT) ? r_pix[r_cnt] : 1'b1;
        end
    end

    always_comb begin
        row_prod   = (8+RECIP_SH+2)'(in_widx) * (8+RECIP_SH+2)'(RECIP);
        ld_row     = ROW_W'(row_prod >> RECIP_SH);
        ld_rowoff  = 16'(ld_row) * 16'(NCOLS);
        ld_col     = COL_W'(16'(in_widx) - ld_rowoff);
        ld_is_hid  = accept && (in_mode == MODE_LOAD) && (32'(in_widx) < HW_DEPTH);
        ld_is_out  = accept && (in_mode == MODE_LOAD) && (32'(in_widx) >= HW_DEPTH)
                     && (32'(in_widx) < HW_DEPTH + NROWS);
        ld_out_idx = in_widx - 9'(HW_DEPTH);
    end

    // lane control
    always_comb begin
        ctl           = '0;
        ctl.acc_clr   = accept;
        ctl.acc_en    = r_rd_v & !r_rd_upd;
        ctl.upd_we    = r_rd_v & r_rd_upd;
        ctl.x_pos     = r_x_d;
        ctl.raddr     = r_cnt;
        ctl.waddr     = r_col_d;
        ctl.h_load    = (r_state == S_HTANH);
        ctl.hhc_load  = (r_state == S_OD1);
        ctl.odw_load  = (r_state == S_OD4);
        ctl.prod_load = (r_state == S_OD5);
        ctl.hd_load   = (r_state == S_OD6);
        ctl.lrhd_load = (r_state == S_OD7);
        ctl.dw_load   = (r_state == S_OD8);
    end

    // one lane per hidden row, bias row first when the bias is on
    for (genvar g = 0; g < NROWS; g++) begin : g_lane
        mbp_lane u_lane (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_active  (r_bias ? 1'b1 : (g < HIDDEN_COUNT)),
            .i_is_bias (r_bias && (g == 0)),
            .i_ld_hid  (ld_is_hid && (ld_row == ROW_W'(g))),
            .i_ld_out  (ld_is_out && (ld_out_idx == 9'(g))),
            .i_ld_col  (ld_col),
            .i_ld_val  (in_wval),
            .i_od      (r_od),
            .i_lr_od   (r_lr_od),
            .i_lr      (r_lr),
            .o_h       (h_vec[g]),
            .o_wout    (w_vec[g])
        );
    end

    // output unit: weighted sum over the lanes, one row a cycle
    mbp_merge u_merge (
        .i_clk (i_clk),
        .i_clr (accept),
        .i_en  (r_state == S_OSUM),
        .i_fin (r_state == S_OTANH),
        .i_row (r_row),
        .i_h   (h_vec),
        .i_w   (w_vec),
        .o_y   (y)
    );

    // snap to plus or minus one beyond the threshold
    always_comb begin
        thr_s = signed'({2'b00, r_thr});
        y_ext = (H_W+1)'(y);
        if (y_ext < -thr_s) begin
            o_nxt   = -t_h'(ONE_Q12);
            dec_nxt = 1'b1;
        end else if (y_ext > thr_s) begin
            o_nxt   = t_h'(ONE_Q12);
            dec_nxt = 1'b1;
        end else begin
            o_nxt   = y;
            dec_nxt = 1'b0;
        end
        t_val = r_tgt ? t_h'(ONE_Q12) : -t_h'(ONE_Q12);
        t_m_o = (H_W+1)'(t_val) - (H_W+1)'(r_o);
        osq   = r_o * r_o;
        lr_s  = signed'({1'b0, r_lr});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (in_mode == MODE_INFER || in_mode == MODE_TRAIN) ? S_HSUM : S_DONE;
                end
            end
            S_HSUM:   n_state = (r_cnt == ncol_last) ? S_HWAIT : S_HSUM;
            S_HWAIT:  n_state = S_HTANH;
            S_HTANH:  n_state = S_OSUM;
            S_OSUM:   n_state = (r_row == nrow_last) ? S_OTANH : S_OSUM;
            S_OTANH:  n_state = S_SNAP;
            S_SNAP: begin
                n_state = S_DONE;
                if (r_mode == MODE_TRAIN && ((o_nxt != t_val))) begin
                    n_state = S_OD1;
                end
            end
            S_OD1:    n_state = S_OD2;
            S_OD2:    n_state = S_OD3;
            S_OD3:    n_state = S_OD4;
            S_OD4:    n_state = S_OD5;
            S_OD5:    n_state = S_OD6;
            S_OD6:    n_state = S_OD7;
            S_OD7:    n_state = S_OD8;
            S_OD8:    n_state = S_UPD;
            S_UPD:    n_state = (r_cnt == ncol_last) ? S_UPWAIT : S_UPD;
            S_UPWAIT: n_state = S_DONE;
            S_DONE:   n_state = out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_W'(3277);
            r_lr        <= LR_W'(410);
            r_bias      <= 1'b1;
            r_rd_v      <= 1'b0;
            r_rd_upd    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_row       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THR:  r_thr  <= i_cfg_data;
                    CFG_LR:   r_lr   <= i_cfg_data;
                    CFG_BIAS: r_bias <= i_cfg_data[0];
                    default:  ;
                endcase
            end
            r_rd_v   <= (r_state == S_HSUM) || (r_state == S_UPD);
            r_rd_upd <= (r_state == S_UPD);
            if (accept || r_state == S_OD8) begin
                r_cnt <= '0;
            end else if (r_state == S_HSUM || r_state == S_UPD) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_HTANH) begin
                r_row <= '0;
            end else if (r_state == S_OSUM) begin
                r_row <= r_row + 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_col_d <= r_cnt;
        r_x_d   <= x_cur;
        if (accept) begin
            r_mode <= in_mode;
            r_pix  <= in_pix;
            r_tgt  <= in_tgt;
            r_upd  <= 1'b0;
        end
        if (r_state == S_SNAP) begin
            r_o    <= o_nxt;
            r_dec  <= dec_nxt;
            r_mism <= (o_nxt != t_val);
            r_upd  <= (r_mode == MODE_TRAIN) && (o_nxt != t_val);
        end
        if (r_state == S_OD1) begin
            r_ooc <= HHC_W'(ONE_Q24) - HHC_W'(osq);
        end
        if (r_state == S_OD2) begin
            r_odp <= r_ooc * t_m_o;
        end
        if (r_state == S_OD3) begin
            r_od <= OD_W'(round_sh(64'(r_odp), 24));
        end
        if (r_state == S_OD4) begin
            r_lr_od <= lr_s * r_od;
        end
        if (r_state == S_DONE && out_free) begin
            if (r_mode == MODE_INFER || r_mode == MODE_TRAIN) begin
                r_out <= OUT_TDATA_W'({r_upd, r_mism, r_dec, r_o});
            end else begin
                r_out <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    `MBP_ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n, (r_state == S_DONE) && out_free,
        m_axis_tvalid && (r_state == S_IDLE), "finished result not presented")
    `MBP_ASSERT_SAME(a_upd_needs_mism, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[16],
        m_axis_tdata[15], "update flagged without a mismatch")
    `MBP_ASSERT_SAME(a_decided_unit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[14],
        (m_axis_tdata[13:0] == 14'h1000) || (m_axis_tdata[13:0] == 14'h3000),
        "decided output is not plus or minus one")
    `MBP_ASSERT_NEXT(a_load_short, i_clk, i_rst_n, accept && (in_mode == MODE_LOAD),
        r_state == S_DONE, "weight load did not go straight to the result")
endmodule
`default_nettype wire
